/* src/vskf_pkg.sv */
package vskf_pkg;

	localparam int TX_QUEUE_DEPTH_DEF = 4;

	localparam logic [15:0] KEEP_ALIVE_RST   = 16'd10000;
	localparam logic [15:0] TX_TAIL_RST      = 16'd1000;
	localparam logic [15:0] SEND_TIMEOUT_RST = 16'd500;

	typedef enum logic [2:0] {
		CFG_PEER_ADDRESS  = 3'd0,
		CFG_KEEP_ALIVE    = 3'd1,
		CFG_TX_TAIL       = 3'd2,
		CFG_SEND_TIMEOUT  = 3'd3,
		CFG_USE_LOCAL     = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		FN_TICK  = 3'd0,
		FN_PKT   = 3'd1,
		FN_SENT  = 3'd2,
		FN_QUEUE = 3'd3,
		FN_STOP  = 3'd4,
		FN_START = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		CH_RTP   = 2'd0,
		CH_RTCP  = 2'd1
	} chan_t;

	typedef enum logic [1:0] {
		PK_OTHER = 2'd0,
		PK_BYE   = 2'd1,
		PK_AUDIO = 2'd2,
		PK_TEXT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		SA_NONE      = 3'd0,
		SA_BYE       = 3'd1,
		SA_SDES      = 3'd2,
		SA_TEXT      = 3'd3,
		SA_AUDIO     = 3'd4,
		SA_RESET_ENC = 3'd5,
		SA_RESET_DEC = 3'd6
	} send_act_t;

	typedef enum logic [1:0] {
		RA_NONE   = 2'd0,
		RA_DECODE = 2'd1,
		RA_TEXT   = 2'd2
	} rx_act_t;

	typedef enum logic [2:0] {
		SC_NONE         = 3'd0,
		SC_PEER_SILENT  = 3'd1,
		SC_SEND_FAILED  = 3'd2,
		SC_ACK_TIMEOUT  = 3'd3,
		SC_ENDED        = 3'd4,
		SC_STOP_TIMEOUT = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE      = 4'd0,
		ST_RX        = 4'd1,
		ST_RX_CPING0 = 4'd2,
		ST_RX_CPING1 = 4'd3,
		ST_RX_DPING0 = 4'd4,
		ST_RX_DPING1 = 4'd5,
		ST_RX_STOP   = 4'd6,
		ST_TX        = 4'd7,
		ST_TX_AUDIO  = 4'd8,
		ST_TX_CPING0 = 4'd9,
		ST_TX_CPING1 = 4'd10,
		ST_OK        = 4'd11,
		ST_FAIL      = 4'd12
	} state_t;

	typedef struct packed {
		logic [31:0] peer_address;
		logic [15:0] keep_alive_ms;
		logic [17:0] keep_alive_x3;
		logic [15:0] tx_tail_ms;
		logic [15:0] send_timeout_ms;
		logic        use_local_ssrc;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] now_ms;
		logic [31:0] src_address;
		logic [1:0]  channel;
		logic [1:0]  packet_kind;
		logic [15:0] rx_seq;
		logic        send_ok;
	} item_t;

	typedef struct packed {
		logic [2:0]  send_action;
		logic [15:0] send_seq;
		logic        sdes_local_ssrc;
		logic [1:0]  rx_action;
		logic [2:0]  status_code;
		logic [3:0]  session_state;
		logic [15:0] seq_errors;
		logic        frame_accepted;
		logic        done_res;
		logic        good;
	} result_t;

	function automatic logic expired(
		input logic [31:0] now,
		input logic [31:0] since,
		input logic [17:0] interval
	);
		logic [31:0] elapsed;
		elapsed = now - since;
		return elapsed > {14'd0, interval};
	endfunction

endpackage

/* src/vskf_cfg.sv */
module vskf_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [2:0]           wr_index,
	input  logic [31:0]          wr_data,
	output vskf_pkg::cfg_t       cfg
);
	import vskf_pkg::*;

	logic [31:0] peer_address_q;
	logic [15:0] keep_alive_q;
	logic [17:0] keep_alive_x3_q;
	logic [15:0] tx_tail_q;
	logic [15:0] send_timeout_q;
	logic        use_local_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_address_q  <= '0;
			keep_alive_q    <= KEEP_ALIVE_RST;
			keep_alive_x3_q <= {2'b00, KEEP_ALIVE_RST} + {1'b0, KEEP_ALIVE_RST, 1'b0};
			tx_tail_q       <= TX_TAIL_RST;
			send_timeout_q  <= SEND_TIMEOUT_RST;
			use_local_q     <= 1'b0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				CFG_PEER_ADDRESS: peer_address_q <= wr_data;
				CFG_KEEP_ALIVE: begin
					keep_alive_q    <= wr_data[15:0];
					keep_alive_x3_q <= {2'b00, wr_data[15:0]} + {1'b0, wr_data[15:0], 1'b0};
				end
				CFG_TX_TAIL:      tx_tail_q      <= wr_data[15:0];
				CFG_SEND_TIMEOUT: send_timeout_q <= wr_data[15:0];
				CFG_USE_LOCAL:    use_local_q    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.peer_address    = peer_address_q;
	assign cfg.keep_alive_ms   = keep_alive_q;
	assign cfg.keep_alive_x3   = keep_alive_x3_q;
	assign cfg.tx_tail_ms      = tx_tail_q;
	assign cfg.send_timeout_ms = send_timeout_q;
	assign cfg.use_local_ssrc  = use_local_q;

endmodule

/* src/vskf_core.sv */
module vskf_core #(
	parameter int TX_QUEUE_DEPTH = vskf_pkg::TX_QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  vskf_pkg::item_t      item,
	input  vskf_pkg::cfg_t       cfg,
	output vskf_pkg::result_t    res
);
	import vskf_pkg::*;

	localparam logic [15:0] DEPTH_W = 16'(TX_QUEUE_DEPTH);

	state_t      mode_q, mode_d;
	logic [31:0] heard_q, heard_d;
	logic [31:0] cping_q, cping_d;
	logic [31:0] dping_q, dping_d;
	logic [31:0] queue_time_q, queue_time_d;
	logic [31:0] ack_q, ack_d;
	logic [15:0] queued_q, queued_d;
	logic [15:0] sent_q, sent_d;
	logic [15:0] last_seq_q, last_seq_d;
	logic [15:0] err_q, err_d;
	logic        stop_q, stop_d;
	logic        bye_q, bye_d;

	send_act_t   act;
	rx_act_t     rxa;
	status_t     status;
	logic [15:0] sseq;
	logic        sdes_loc;
	logic        acc;
	logic        in_rx;
	logic        in_tx;
	logic [31:0] ack_delta;
	logic        ack_exp;
	logic [31:0] arm_deadline;
	logic [15:0] backlog;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ST_IDLE;
			heard_q      <= '0;
			cping_q      <= '0;
			dping_q      <= '0;
			queue_time_q <= '0;
			ack_q        <= '0;
			queued_q     <= '0;
			sent_q       <= '0;
			last_seq_q   <= '0;
			err_q        <= '0;
			stop_q       <= 1'b0;
			bye_q        <= 1'b0;
		end else if (fire) begin
			mode_q       <= mode_d;
			heard_q      <= heard_d;
			cping_q      <= cping_d;
			dping_q      <= dping_d;
			queue_time_q <= queue_time_d;
			ack_q        <= ack_d;
			queued_q     <= queued_d;
			sent_q       <= sent_d;
			last_seq_q   <= last_seq_d;
			err_q        <= err_d;
			stop_q       <= stop_d;
			bye_q        <= bye_d;
		end
	end

	assign ack_delta    = item.now_ms - ack_q;
	assign ack_exp      = (ack_delta != '0) && !ack_delta[31];
	assign arm_deadline = item.now_ms + {16'd0, cfg.send_timeout_ms};
	assign backlog      = queued_q - sent_q;
	assign in_rx        = mode_q inside {[ST_RX : ST_RX_STOP]};
	assign in_tx        = mode_q inside {[ST_TX : ST_TX_CPING1]};

	always_comb begin
		mode_d       = mode_q;
		heard_d      = heard_q;
		cping_d      = cping_q;
		dping_d      = dping_q;
		queue_time_d = queue_time_q;
		ack_d        = ack_q;
		queued_d     = queued_q;
		sent_d       = sent_q;
		last_seq_d   = last_seq_q;
		err_d        = err_q;
		stop_d       = stop_q;
		bye_d        = bye_q;
		act          = SA_NONE;
		rxa          = RA_NONE;
		status       = SC_NONE;
		sseq         = '0;
		sdes_loc     = 1'b0;
		acc          = 1'b0;

		case (func_t'(item.func))
			FN_QUEUE: begin
				if (backlog < DEPTH_W) begin
					queued_d     = queued_q + 16'd1;
					queue_time_d = item.now_ms;
					acc          = 1'b1;
				end
			end
			FN_STOP: stop_d = 1'b1;
			FN_START: begin
				cping_d      = '0;
				dping_d      = '0;
				heard_d      = item.now_ms;
				queued_d     = '0;
				sent_d       = '0;
				queue_time_d = '0;
				last_seq_d   = '0;
				err_d        = '0;
				stop_d       = 1'b0;
				bye_d        = 1'b0;
				mode_d       = ST_RX;
			end
			FN_TICK, FN_PKT, FN_SENT: begin
				if (!(item.func == FN_PKT && item.src_address != cfg.peer_address)) begin
					if (item.func == FN_PKT && (in_rx || in_tx)) begin
						if (item.channel == CH_RTCP) begin
							if (item.packet_kind == PK_BYE)
								bye_d = 1'b1;
						end else if (item.channel == CH_RTP) begin
							if (in_rx && item.packet_kind == PK_AUDIO) begin
								if (item.rx_seq <= last_seq_q && err_q != 16'hFFFF)
									err_d = err_q + 16'd1;
								last_seq_d = item.rx_seq;
								rxa        = RA_DECODE;
							end else if (item.packet_kind == PK_TEXT) begin
								rxa = RA_TEXT;
							end
						end
						heard_d = item.now_ms;
					end
					case (mode_q)
						ST_RX: begin
							if (stop_q || bye_d) begin
								act    = SA_BYE;
								mode_d = ST_RX_STOP;
								ack_d  = arm_deadline;
							end else if (queued_q != sent_q) begin
								act    = SA_RESET_ENC;
								mode_d = ST_TX;
							end else if (expired(item.now_ms, heard_d, cfg.keep_alive_x3)) begin
								status = SC_PEER_SILENT;
								mode_d = ST_FAIL;
							end else if (expired(item.now_ms, cping_q,
								{2'b00, cfg.keep_alive_ms})) begin
								mode_d = ST_RX_CPING0;
							end else if (expired(item.now_ms, dping_q,
								{2'b00, cfg.keep_alive_ms})) begin
								mode_d = ST_RX_DPING0;
							end
						end
						ST_RX_CPING0: begin
							act      = SA_SDES;
							sdes_loc = cfg.use_local_ssrc;
							cping_d  = item.now_ms;
							mode_d   = ST_RX_CPING1;
							ack_d    = arm_deadline;
						end
						ST_RX_DPING0: begin
							act     = SA_TEXT;
							dping_d = item.now_ms;
							mode_d  = ST_RX_DPING1;
							ack_d   = arm_deadline;
						end
						ST_RX_CPING1, ST_RX_DPING1, ST_TX_AUDIO, ST_TX_CPING1: begin
							if (item.func == FN_SENT) begin
								if (!item.send_ok)
									status = SC_SEND_FAILED;
								mode_d = in_tx ? ST_TX : ST_RX;
							end else if (ack_exp) begin
								status = SC_ACK_TIMEOUT;
								mode_d = ST_FAIL;
							end
						end
						ST_RX_STOP: begin
							if (item.func == FN_SENT) begin
								status = SC_ENDED;
								mode_d = ST_OK;
							end else if (ack_exp) begin
								status = SC_STOP_TIMEOUT;
								mode_d = ST_FAIL;
							end
						end
						ST_TX: begin
							if (queued_q != sent_q) begin
								act    = SA_AUDIO;
								sseq   = sent_q;
								sent_d = sent_q + 16'd1;
								mode_d = ST_TX_AUDIO;
								ack_d  = arm_deadline;
							end else if (expired(item.now_ms, queue_time_q,
								{2'b00, cfg.tx_tail_ms})) begin
								act    = SA_RESET_DEC;
								mode_d = ST_RX;
							end else if (expired(item.now_ms, heard_d, cfg.keep_alive_x3)) begin
								status = SC_PEER_SILENT;
								mode_d = ST_FAIL;
							end else if (expired(item.now_ms, cping_q,
								{2'b00, cfg.keep_alive_ms})) begin
								mode_d = ST_TX_CPING0;
							end
						end
						ST_TX_CPING0: begin
							act     = SA_SDES;
							cping_d = item.now_ms;
							mode_d  = ST_TX_CPING1;
							ack_d   = arm_deadline;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign res.send_action     = act;
	assign res.send_seq        = sseq;
	assign res.sdes_local_ssrc = sdes_loc;
	assign res.rx_action       = rxa;
	assign res.status_code     = status;
	assign res.session_state   = mode_d;
	assign res.seq_errors      = err_d;
	assign res.frame_accepted  = acc;
	assign res.done_res        = (mode_d == ST_OK) || (mode_d == ST_FAIL);
	assign res.good            = (mode_d == ST_OK);

endmodule

/* src/voip_session_keepalive_fsm.sv */
// An accepted input beat passes the input register, then the result register.
// Throughput: one event per cycle while out_stall is low; the session state updates in one pass.
// Reset (arst_n low): session idle, all timers and counters zero,
// configuration back to defaults (keep-alive 10000, tail 1000, send timeout 500).
module voip_session_keepalive_fsm #(
	parameter int TX_QUEUE_DEPTH = vskf_pkg::TX_QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [31:0] now_ms,
	input  logic [31:0] src_address,
	input  logic [1:0]  channel,
	input  logic [1:0]  packet_kind,
	input  logic [15:0] rx_seq,
	input  logic        send_ok,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  send_action,
	output logic [15:0] send_seq,
	output logic        sdes_local_ssrc,
	output logic [1:0]  rx_action,
	output logic [2:0]  status_code,
	output logic [3:0]  session_state,
	output logic [15:0] seq_errors,
	output logic        frame_accepted,
	output logic        done_res,
	output logic        good,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import vskf_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;

	vskf_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// hold the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.func        <= func;
			item_s1.now_ms      <= now_ms;
			item_s1.src_address <= src_address;
			item_s1.channel     <= channel;
			item_s1.packet_kind <= packet_kind;
			item_s1.rx_seq      <= rx_seq;
			item_s1.send_ok     <= send_ok;
		end
	end

	vskf_core #(
		.TX_QUEUE_DEPTH (TX_QUEUE_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_comb;
	end

	assign out_valid       = valid_s2;
	assign send_action     = res_s2.send_action;
	assign send_seq        = res_s2.send_seq;
	assign sdes_local_ssrc = res_s2.sdes_local_ssrc;
	assign rx_action       = res_s2.rx_action;
	assign status_code     = res_s2.status_code;
	assign session_state   = res_s2.session_state;
	assign seq_errors      = res_s2.seq_errors;
	assign frame_accepted  = res_s2.frame_accepted;
	assign done_res        = res_s2.done_res;
	assign good            = res_s2.good;

endmodule
